/* rtl/cab_pkg.sv */
// Shared types, codes and a helper function for the canvas alpha blend unit.
package cab_pkg;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BLEND = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PLACE_X       = 3'd2;
  localparam logic [2:0] REG_PLACE_Y       = 3'd3;
  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd5;

  // Width of the configuration write data (widest register).
  localparam int unsigned CFG_DW = 11;

  // Full-scale channel value.
  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // One RGBA pixel as stored in the canvas, red in the low byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_DATA  = 5'b00100,
    ST_MIX   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // Truncating division by 255, exact for every value below 65280.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return t[15:8];
  endfunction

endpackage

/* rtl/cab_canvas_mem.sv */
// Single-port synchronous canvas memory with a registered read port.
module cab_canvas_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic            clk,
  input  logic            we,
  input  logic            re,
  input  logic [AW-1:0]   addr,
  input  cab_pkg::pixel_t wdata,
  output cab_pkg::pixel_t rdata
);

  cab_pkg::pixel_t mem [DEPTH];
  cab_pkg::pixel_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read port, registered data appears in the cycle after the request and is held until the next one.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/cab_blend_dp.sv */
// Over-operator datapath: registered channel products, then divide by 255; alpha is a saturating sum.
module cab_blend_dp (
  input  logic            clk,
  input  logic            load,
  input  cab_pkg::pixel_t dst,
  input  cab_pkg::pixel_t src,
  output cab_pkg::pixel_t blended
);

  logic [15:0] red_sum_r,   red_sum_nxt;
  logic [15:0] green_sum_r, green_sum_nxt;
  logic [15:0] blue_sum_r,  blue_sum_nxt;
  logic [7:0]  alpha_r,     alpha_nxt;
  logic [7:0]  inv_a;
  logic [8:0]  alpha_sum;

  // Weighted sums of destination and source per color channel.
  always_comb begin
    inv_a         = cab_pkg::CHAN_MAX - src.alpha;
    red_sum_nxt   = 16'(dst.red   * inv_a) + 16'(src.red   * src.alpha);
    green_sum_nxt = 16'(dst.green * inv_a) + 16'(src.green * src.alpha);
    blue_sum_nxt  = 16'(dst.blue  * inv_a) + 16'(src.blue  * src.alpha);
    alpha_sum     = {1'b0, dst.alpha} + {1'b0, src.alpha};
    alpha_nxt     = alpha_sum[8] ? cab_pkg::CHAN_MAX : alpha_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_sum_r   <= red_sum_nxt;
      green_sum_r <= green_sum_nxt;
      blue_sum_r  <= blue_sum_nxt;
      alpha_r     <= alpha_nxt;
    end
  end

  // Normalize the registered sums back to eight bits.
  always_comb begin
    blended.red   = cab_pkg::div255(red_sum_r);
    blended.green = cab_pkg::div255(green_sum_r);
    blended.blue  = cab_pkg::div255(blue_sum_r);
    blended.alpha = alpha_r;
  end

endmodule

/* rtl/canvas_alpha_blend_unit.sv */
// Canvas alpha blend unit: configuration, transaction sequencer and output register.
// Each transaction runs read or write, multiply, normalize and write-back through the
// single-port canvas memory, and no new transaction is accepted until the previous
// result has been loaded into the output register.
// Reset: configuration returns to its defaults and the sequencer and output go idle;
// the canvas contents are not cleared and are undefined until written.
module canvas_alpha_blend_unit #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration port
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [cab_pkg::CFG_DW-1:0]  cfg_wdata,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [6:0]                  in_col,
  input  logic [6:0]                  in_row,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic [7:0]                  in_alpha,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_alpha,
  output logic                        out_hit
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [10:0] MaxW  = 11'(MAX_WIDTH);
  localparam logic [10:0] MaxH  = 11'(MAX_HEIGHT);

  // Configuration registers.
  logic [7:0]  canvas_width_r;
  logic [7:0]  canvas_height_r;
  logic [10:0] place_x_r;
  logic [10:0] place_y_r;
  logic [7:0]  source_width_r;
  logic [7:0]  source_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= 8'd128;
      canvas_height_r <= 8'd128;
      place_x_r       <= 11'd0;
      place_y_r       <= 11'd0;
      source_width_r  <= 8'd128;
      source_height_r <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        cab_pkg::REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_wdata[7:0];
        cab_pkg::REG_CANVAS_HEIGHT: canvas_height_r <= cfg_wdata[7:0];
        cab_pkg::REG_PLACE_X:       place_x_r       <= cfg_wdata;
        cab_pkg::REG_PLACE_Y:       place_y_r       <= cfg_wdata;
        cab_pkg::REG_SOURCE_WIDTH:  source_width_r  <= cfg_wdata[7:0];
        cab_pkg::REG_SOURCE_HEIGHT: source_height_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer and transaction registers.
  cab_pkg::state_t state_r, state_nxt;
  cab_pkg::op_t    op_r;
  logic            hit_r;
  logic [AW-1:0]   addr_r;
  cab_pkg::pixel_t src_r;
  cab_pkg::pixel_t res_r, res_nxt;

  logic            accept;
  cab_pkg::op_t    in_op;
  logic [11:0]     x, y;
  logic            in_canvas, in_source, hit_nxt;
  logic [AW-1:0]   addr_nxt;

  assign in_stall = (state_r != cab_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_op    = cab_pkg::op_t'(in_operation);

  // Target position: blends are offset by the placement, other operations are direct.
  always_comb begin
    if (in_op == cab_pkg::OP_BLEND) begin
      x = {place_x_r[10], place_x_r} + {5'd0, in_col};
      y = {place_y_r[10], place_y_r} + {5'd0, in_row};
    end else begin
      x = {5'd0, in_col};
      y = {5'd0, in_row};
    end
    in_canvas = !x[11] && !y[11]
             && (x[10:0] < {3'd0, canvas_width_r})  && (x[10:0] < MaxW)
             && (y[10:0] < {3'd0, canvas_height_r}) && (y[10:0] < MaxH);
    in_source = ({1'b0, in_col} < source_width_r) && ({1'b0, in_row} < source_height_r);
    case (in_op)
      cab_pkg::OP_WRITE: hit_nxt = in_canvas;
      cab_pkg::OP_READ:  hit_nxt = in_canvas;
      cab_pkg::OP_BLEND: hit_nxt = in_canvas && in_source;
      default:           hit_nxt = 1'b0;
    endcase
    addr_nxt = AW'(y[10:0]) * AW'(MAX_WIDTH) + AW'(x[10:0]);
  end

  // Capture the transaction at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      hit_r  <= hit_nxt;
      addr_r <= addr_nxt;
      src_r  <= '{alpha: in_alpha, blue: in_blue, green: in_green, red: in_red};
    end
  end

  // Memory and blend datapath.
  logic            mem_we, mem_re, dp_load;
  cab_pkg::pixel_t mem_wdata, mem_rdata, blended;

  cab_canvas_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (addr_r),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  cab_blend_dp u_dp (
    .clk     (clk),
    .load    (dp_load),
    .dst     (mem_rdata),
    .src     (src_r),
    .blended (blended)
  );

  logic out_free;
  logic out_valid_r;

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: issue the access, multiply, normalize and write back, then deliver.
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = src_r;
    dp_load   = 1'b0;
    res_nxt   = res_r;
    case (state_r)
      cab_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = cab_pkg::ST_ISSUE;
        end
      end
      cab_pkg::ST_ISSUE: begin
        mem_we    = (op_r == cab_pkg::OP_WRITE) && hit_r;
        mem_re    = !mem_we;
        state_nxt = cab_pkg::ST_DATA;
      end
      cab_pkg::ST_DATA: begin
        dp_load   = 1'b1;
        state_nxt = cab_pkg::ST_MIX;
      end
      cab_pkg::ST_MIX: begin
        mem_we    = (op_r == cab_pkg::OP_BLEND) && hit_r;
        mem_wdata = blended;
        res_nxt   = '0;
        if (hit_r) begin
          case (op_r)
            cab_pkg::OP_READ:  res_nxt = mem_rdata;
            cab_pkg::OP_BLEND: res_nxt = blended;
            default:           res_nxt = '0;
          endcase
        end
        state_nxt = cab_pkg::ST_OUT;
      end
      cab_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = cab_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cab_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cab_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Output register.
  logic            load_out;
  cab_pkg::pixel_t out_pix_r;
  logic            out_hit_r;

  assign load_out = (state_r == cab_pkg::ST_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pix_r <= res_r;
      out_hit_r <= hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r.red;
  assign out_green = out_pix_r.green;
  assign out_blue  = out_pix_r.blue;
  assign out_alpha = out_pix_r.alpha;
  assign out_hit   = out_hit_r;

endmodule
